FILE: hw/rtl/sle_pkg.sv
package sle_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT   = 2'd0,
    KIND_REMOVE   = 2'd1,
    KIND_CONTAINS = 2'd2,
    KIND_CLEAR    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  localparam int unsigned ValueW = 32;
  localparam int unsigned OccW   = 5;

  typedef logic signed [ValueW-1:0] value_t;

  typedef struct packed {
    logic do_ins;
    logic do_rem;
  } cell_ctl_t;

endpackage

FILE: hw/rtl/sle_if.sv
interface sle_item_if;
  logic             valid;
  logic             ready;
  sle_pkg::kind_t   kind;
  sle_pkg::value_t  value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface sle_result_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  sle_pkg::status_t            status;
  logic [sle_pkg::OccW-1:0]    occupancy;

  modport source (output valid, output found, output status, output occupancy, input ready);
  modport sink   (input valid, input found, input status, input occupancy, output ready);
endinterface

FILE: hw/rtl/sorted_list_engine.sv
// Sorted list engine: keeps up to CAPACITY signed 32-bit values in ascending order,
// duplicates allowed, in a row of cells that each hold one entry and compare it with
// the request in parallel. Every request (insert, remove, contains, clear) is applied
// on acceptance and gives one registered result, so one transfer per cycle is
// sustained while the receiver takes results; a new request enters in the cycle the
// previous result is taken, and the input stalls while a result waits. Insert into
// a full list returns status full, remove or contains of an absent value returns
// not found, and occupancy reports the low 5 bits of the count after the operation.
module sorted_list_engine #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  sle_item_if.sink      in_item,
  sle_result_if.source  out_result
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0]           count_r;
  logic [CntW-1:0]           count_nxt;
  logic                      out_valid_r;
  logic                      found_r;
  sle_pkg::status_t          status_r;
  logic [sle_pkg::OccW-1:0]  occ_r;

  logic                      accept;
  logic                      full;
  logic                      present;
  sle_pkg::status_t          status_nxt;
  sle_pkg::cell_ctl_t        ctl;

  sle_pkg::value_t           entry [CAPACITY];
  logic [CAPACITY-1:0]       lt;
  logic [CAPACITY-1:0]       eq;

  assign in_item.ready = !out_valid_r || out_result.ready;
  assign accept        = in_item.valid && in_item.ready;
  assign full          = (count_r == CntW'(CAPACITY));
  assign present       = |eq;

  assign ctl.do_ins = (in_item.kind == sle_pkg::KIND_INSERT) && !full;
  assign ctl.do_rem = (in_item.kind == sle_pkg::KIND_REMOVE) && present;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sle_cell u_cell (
      .clk         (clk),
      .en          (accept),
      .ctl         (ctl),
      .occ         (CntW'(i) < count_r),
      .key         (in_item.value),
      .left_lt     ((i == 0) ? 1'b1 : lt[(i == 0) ? 0 : i - 1]),
      .left_entry  ((i == 0) ? in_item.value : entry[(i == 0) ? 0 : i - 1]),
      .right_entry ((i == CAPACITY - 1) ? in_item.value
                                        : entry[(i == CAPACITY - 1) ? i : i + 1]),
      .entry       (entry[i]),
      .lt          (lt[i]),
      .eq          (eq[i])
    );
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = sle_pkg::ST_OK;
    unique case (in_item.kind)
      sle_pkg::KIND_INSERT: begin
        if (full) begin
          status_nxt = sle_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + CntW'(1);
        end
      end
      sle_pkg::KIND_REMOVE: begin
        if (present) begin
          count_nxt = count_r - CntW'(1);
        end else begin
          status_nxt = sle_pkg::ST_NOT_FOUND;
        end
      end
      sle_pkg::KIND_CONTAINS: begin
        status_nxt = present ? sle_pkg::ST_OK : sle_pkg::ST_NOT_FOUND;
      end
      sle_pkg::KIND_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_result.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      found_r  <= present;
      status_r <= status_nxt;
      occ_r    <= sle_pkg::OccW'(count_nxt);
    end
  end

  assign out_result.valid     = out_valid_r;
  assign out_result.found     = found_r;
  assign out_result.status    = status_r;
  assign out_result.occupancy = occ_r;

endmodule

FILE: hw/rtl/sle_cell.sv
module sle_cell (
  input  logic                clk,
  input  logic                en,
  input  sle_pkg::cell_ctl_t  ctl,
  input  logic                occ,
  input  sle_pkg::value_t     key,
  input  logic                left_lt,
  input  sle_pkg::value_t     left_entry,
  input  sle_pkg::value_t     right_entry,
  output sle_pkg::value_t     entry,
  output logic                lt,
  output logic                eq
);

  sle_pkg::value_t entry_r;
  sle_pkg::value_t entry_nxt;

  assign entry = entry_r;
  assign lt    = occ && (entry_r < key);
  assign eq    = occ && (entry_r == key);

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.do_ins && !lt) begin
      entry_nxt = left_lt ? key : left_entry;
    end else if (ctl.do_rem && !lt) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      entry_r <= entry_nxt;
    end
  end

endmodule

FILE: dv/tb.sv
module tb;

  localparam int unsigned CAPACITY   = 16;
  localparam int          CycleLimit = 400000;
  localparam int          PoolSize   = 8;

  typedef struct packed {
    sle_pkg::kind_t  kind;
    sle_pkg::value_t value;
  } list_op_t;

  typedef struct packed {
    logic                     found;
    sle_pkg::status_t         status;
    logic [sle_pkg::OccW-1:0] occupancy;
  } list_outcome_t;

  logic clk;
  logic rst_n;

  sle_item_if   item_bus ();
  sle_result_if result_bus ();

  sorted_list_engine #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (item_bus),
    .out_result(result_bus)
  );

  list_op_t        pending_ops[$];
  list_outcome_t   expected_outcomes[$];
  sle_pkg::value_t stored_vals[$];
  sle_pkg::value_t value_pool[PoolSize];

  int  ops_sent;
  int  outcomes_seen;
  int  mismatches;
  int  cycle_count;
  int  full_refusals;
  int  times_emptied;
  int  hold_asks;
  int  holds_done;
  bit  took_op;
  bit  sender_idle;
  bit  sink_stall;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // one list operation applied to the local copy of the list
  function automatic list_outcome_t list_apply(sle_pkg::kind_t kind, sle_pkg::value_t v);
    list_outcome_t res;
    int            pos;
    bit            present;
    int            count_before;
    count_before = stored_vals.size();
    pos = 0;
    while (pos < stored_vals.size() && stored_vals[pos] < v)
      pos++;
    present = (pos < stored_vals.size()) && (stored_vals[pos] == v);
    res.status = sle_pkg::ST_OK;
    case (kind)
      sle_pkg::KIND_INSERT: begin
        if (stored_vals.size() >= CAPACITY) begin
          res.status = sle_pkg::ST_FULL;
          full_refusals++;
        end else begin
          stored_vals.insert(pos, v);
        end
      end
      sle_pkg::KIND_REMOVE: begin
        if (present) stored_vals.delete(pos);
        else res.status = sle_pkg::ST_NOT_FOUND;
      end
      sle_pkg::KIND_CONTAINS: begin
        res.status = present ? sle_pkg::ST_OK : sle_pkg::ST_NOT_FOUND;
      end
      default: begin
        stored_vals.delete();
      end
    endcase
    if (count_before > 0 && stored_vals.size() == 0) times_emptied++;
    res.found     = present;
    res.occupancy = sle_pkg::OccW'(stored_vals.size());
    return res;
  endfunction

  task automatic queue_op(sle_pkg::kind_t kind, sle_pkg::value_t v);
    list_op_t op;
    op.kind  = kind;
    op.value = v;
    pending_ops.push_back(op);
  endtask

  // narrow values give many duplicates, the pool gives repeats over the full range
  function automatic list_op_t rand_op(bit narrow, int ins_pct);
    list_op_t op;
    int       r;
    int       w;
    r = $urandom_range(0, 99);
    if (r < ins_pct) op.kind = sle_pkg::KIND_INSERT;
    else if (r < ins_pct + (97 - ins_pct) / 2) op.kind = sle_pkg::KIND_REMOVE;
    else if (r < 97) op.kind = sle_pkg::KIND_CONTAINS;
    else op.kind = sle_pkg::KIND_CLEAR;
    w = $urandom_range(0, 99);
    if (narrow) begin
      op.value = sle_pkg::value_t'(int'($urandom_range(0, 8)) - 4);
    end else if (w < 70) begin
      op.value = value_pool[$urandom_range(0, PoolSize - 1)];
    end else if (w < 80) begin
      case ($urandom_range(0, 3))
        0: op.value = sle_pkg::value_t'(32'h8000_0000);
        1: op.value = sle_pkg::value_t'(32'h7fff_ffff);
        2: op.value = '0;
        default: op.value = '1;
      endcase
    end else begin
      op.value = sle_pkg::value_t'($urandom);
    end
    return op;
  endfunction

  task automatic fill_phase(int count, bit narrow, int ins_pct);
    for (int i = 0; i < PoolSize; i++)
      value_pool[i] = sle_pkg::value_t'($urandom);
    for (int i = 0; i < count; i++)
      pending_ops.push_back(rand_op(narrow, ins_pct));
  endtask

  task automatic drain();
    while (pending_ops.size() != 0 || expected_outcomes.size() != 0)
      @(posedge clk);
  endtask

  task automatic wait_sent(int target);
    while (ops_sent < target)
      @(posedge clk);
  endtask

  // transfer on the input side: predict and retire the op
  always @(posedge clk) begin
    took_op = 1'b0;
    if (rst_n && item_bus.valid && item_bus.ready) begin
      expected_outcomes.push_back(list_apply(item_bus.kind, item_bus.value));
      void'(pending_ops.pop_front());
      ops_sent++;
      took_op = 1'b1;
    end
  end

  // sender: bursts of random length, with random gaps while sender_idle is set
  int burst_left = 1;
  int gap_left   = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      item_bus.valid <= 1'b0;
    end else if (item_bus.valid && !took_op) begin
      // hold the offered op until it is taken
    end else if (gap_left > 0) begin
      gap_left--;
      item_bus.valid <= 1'b0;
    end else if (pending_ops.size() != 0) begin
      item_bus.valid <= 1'b1;
      item_bus.kind  <= pending_ops[0].kind;
      item_bus.value <= pending_ops[0].value;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left   = sender_idle ? $urandom_range(1, 7) : 0;
      end
    end else begin
      item_bus.valid <= 1'b0;
    end
  end

  // receiver: always ready, or a rotating stall pattern while sink_stall is set, plus long hold-offs on request
  int          hold_left = 0;
  int          pat_idx   = 0;
  logic [15:0] stall_pattern = 16'hffff;
  always @(negedge clk) begin
    if (!rst_n) begin
      result_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_bus.ready <= 1'b0;
    end else if (hold_asks != holds_done) begin
      holds_done++;
      hold_left = 60;
      result_bus.ready <= 1'b0;
    end else if (!sink_stall) begin
      result_bus.ready <= 1'b1;
    end else begin
      result_bus.ready <= stall_pattern[pat_idx];
      pat_idx = (pat_idx + 1) % 16;
      if (pat_idx == 0 && $urandom_range(0, 3) == 0)
        stall_pattern = 16'($urandom | $urandom);
    end
  end

  // result checking
  always @(posedge clk) begin
    list_outcome_t got;
    list_outcome_t want;
    if (rst_n && result_bus.valid && result_bus.ready) begin
      got.found     = result_bus.found;
      got.status    = result_bus.status;
      got.occupancy = result_bus.occupancy;
      outcomes_seen++;
      if (expected_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with none outstanding: found=%0b status=%0d occupancy=%0d",
                   got.found, got.status, got.occupancy);
      end else begin
        want = expected_outcomes.pop_front();
        if (got.found !== want.found || got.status !== want.status ||
            got.occupancy !== want.occupancy) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected %0b/%0d/%0d, got %0b/%0d/%0d",
                     outcomes_seen, want.found, want.status, want.occupancy,
                     got.found, got.status, got.occupancy);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d ops outstanding", cycle_count,
               pending_ops.size() + expected_outcomes.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_n            = 1'b0;
    item_bus.valid   = 1'b0;
    item_bus.kind    = sle_pkg::KIND_INSERT;
    item_bus.value   = '0;
    result_bus.ready = 1'b0;
    sender_idle      = 1'b0;
    sink_stall       = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty list, extremes, duplicates, absent values, fill to full, clear
    queue_op(sle_pkg::KIND_CONTAINS, sle_pkg::value_t'(32'h8000_0000));
    queue_op(sle_pkg::KIND_REMOVE, sle_pkg::value_t'(32'h7fff_ffff));
    queue_op(sle_pkg::KIND_CLEAR, '0);
    queue_op(sle_pkg::KIND_INSERT, sle_pkg::value_t'(32'h7fff_ffff));
    queue_op(sle_pkg::KIND_INSERT, sle_pkg::value_t'(32'h8000_0000));
    queue_op(sle_pkg::KIND_INSERT, '0);
    queue_op(sle_pkg::KIND_INSERT, '0);
    queue_op(sle_pkg::KIND_INSERT, '1);
    queue_op(sle_pkg::KIND_CONTAINS, '0);
    queue_op(sle_pkg::KIND_CONTAINS, sle_pkg::value_t'(1));
    queue_op(sle_pkg::KIND_REMOVE, '0);
    queue_op(sle_pkg::KIND_REMOVE, sle_pkg::value_t'(7));
    for (int i = 0; i < 12; i++)
      queue_op(sle_pkg::KIND_INSERT,
               sle_pkg::value_t'((i * 32'h1357_9bdf) ^ 32'haaaa_5555));
    queue_op(sle_pkg::KIND_INSERT, sle_pkg::value_t'(32'h5555_aaaa));
    queue_op(sle_pkg::KIND_CONTAINS, sle_pkg::value_t'(32'h7fff_ffff));
    queue_op(sle_pkg::KIND_CLEAR, '0);
    drain();

    fill_phase(500, 1'b1, 45);
    drain();

    sender_idle = 1'b1;
    sink_stall  = 1'b1;
    fill_phase(500, 1'b0, 45);
    drain();

    // receiver holds off while the sender keeps offering
    fill_phase(500, 1'b0, 30);
    wait_sent(ops_sent + 40);
    sender_idle = 1'b0;
    hold_asks++;
    wait_sent(ops_sent + 150);
    hold_asks++;
    sender_idle = 1'b1;
    drain();

    sender_idle = 1'b0;
    fill_phase(500, 1'b0, 50);
    drain();

    repeat (6) @(posedge clk);
    $display("%0d operations sent, %0d results checked in %0d cycles", ops_sent,
             outcomes_seen, cycle_count);
    $display("inserts refused on a full list: %0d, list emptied %0d times",
             full_refusals, times_emptied);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching results", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
